// File: sv/hkt_pkg.sv
// Shared types, field widths and constants of the hashed key table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hkt_pkg;

	localparam int KEY_W      = 44;
	localparam int REF_W      = 16;
	localparam int SLOT_W     = 1 + KEY_W + REF_W;
	localparam int BCOUNT_W   = 9;
	localparam int NEFF_W     = 10;
	localparam int DEF_BUCKETS = 256;
	localparam int DEF_WAYS    = 4;

	// Mixing constants of the 64-bit finalizer.
	localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int FMIX_SHIFT = 33;

	// Register indexes of the configuration port.
	localparam int REG_BUCKET_COUNT = 0;
	localparam logic [BCOUNT_W-1:0] BUCKET_COUNT_RESET = 9'd256;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_e_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [KEY_W-1:0] key;
		logic [REF_W-1:0] book_ref;
	} req_t;

	typedef struct packed {
		status_e_t        status;
		logic [REF_W-1:0] found_ref;
	} result_t;

endpackage

// File: sv/hkt_bucket.sv
// Bucket selection: fmix64 of the key on a shared 32x32 multiplier,
// then the low 32 bits reduced modulo the bucket count, 8 bits a cycle.
// Depends on hkt_pkg.
`timescale 1ns / 1ps

module hkt_bucket #(
	parameter int BUCKETS = hkt_pkg::DEF_BUCKETS,
	parameter int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hkt_pkg::KEY_W-1:0]   key,
	input  logic [hkt_pkg::NEFF_W-1:0]  n_eff,
	output logic                        done,
	output logic [BW-1:0]               bucket
);
	import hkt_pkg::*;

	logic        mul_busy_q, mod_busy_q, done_q;
	logic [2:0]  ph_q;
	logic [1:0]  mod_cnt_q;
	logic [63:0] x_q, acc_q, prod_q;
	logic [31:0] div_q;
	logic [NEFF_W-1:0] rem_q;
	logic [BW-1:0] bucket_q;

	logic [63:0] cst, key64, sum;
	logic [31:0] op_a, op_b, div_n;
	logic [NEFF_W-1:0] rem_n;
	logic [31:0] rem_ext;

	assign key64 = {20'b0, key};
	assign cst = ph_q[2] ? FMIX_C2 : FMIX_C1;
	assign sum = acc_q + {prod_q[31:0], 32'b0};

	// Operand selection for the partial products of the low 64-bit product.
	always_comb begin
		case (ph_q[1:0])
			2'd0: begin
				op_a = x_q[31:0];
				op_b = cst[31:0];
			end
			2'd1: begin
				op_a = x_q[31:0];
				op_b = cst[63:32];
			end
			default: begin
				op_a = x_q[63:32];
				op_b = cst[31:0];
			end
		endcase
	end

	// Eight restoring division steps on the remainder.
	always_comb begin
		rem_n = rem_q;
		div_n = div_q;
		for (int i = 0; i < 8; i++) begin
			rem_n = {rem_n[NEFF_W-2:0], div_n[31]};
			div_n = {div_n[30:0], 1'b0};
			if (rem_n >= n_eff) begin
				rem_n = rem_n - n_eff;
			end
		end
	end

	assign rem_ext = {{(32-NEFF_W){1'b0}}, rem_n};

	// Sequencer of the two multiplies and the modulo.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mod_busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q <= '0;
			mod_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mul_busy_q <= 1'b1;
				ph_q <= '0;
			end else if (mul_busy_q) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd7) begin
					mul_busy_q <= 1'b0;
					mod_busy_q <= 1'b1;
					mod_cnt_q <= '0;
				end
			end else if (mod_busy_q) begin
				mod_cnt_q <= mod_cnt_q + 2'd1;
				if (mod_cnt_q == 2'd3) begin
					mod_busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= key64 ^ (key64 >> FMIX_SHIFT);
		end else if (mul_busy_q) begin
			prod_q <= {32'b0, op_a} * {32'b0, op_b};
			case (ph_q[1:0])
				2'd1: acc_q <= prod_q;
				2'd2: acc_q <= sum;
				2'd3: x_q <= sum ^ (sum >> FMIX_SHIFT);
				default: acc_q <= acc_q;
			endcase
			if (ph_q == 3'd7) begin
				div_q <= sum[31:0] ^ {1'b0, sum[63:FMIX_SHIFT]};
				rem_q <= '0;
			end
		end else if (mod_busy_q) begin
			div_q <= div_n;
			rem_q <= rem_n;
			if (mod_cnt_q == 2'd3) begin
				bucket_q <= rem_ext[BW-1:0];
			end
		end
	end

	assign done = done_q;
	assign bucket = bucket_q;

endmodule

// File: sv/hkt_table.sv
// Slot memory, one row of WAYS slots per bucket, with the clearing pass,
// the probe of a row and the write-back of the changed row.
// Depends on hkt_pkg.
`timescale 1ns / 1ps

module hkt_table #(
	parameter int BUCKETS = hkt_pkg::DEF_BUCKETS,
	parameter int WAYS = hkt_pkg::DEF_WAYS,
	parameter int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [BW-1:0]    rd_addr,
	input  hkt_pkg::req_t    req,
	input  logic             commit,
	output hkt_pkg::result_t result,
	output logic             wr_active,
	output logic             clr_busy
);
	import hkt_pkg::*;

	localparam int ROW_W = WAYS * SLOT_W;
	localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [ROW_W-1:0] mem [BUCKETS];
	logic [ROW_W-1:0] row_q, new_row, wr_data;
	logic [BW-1:0]    addr_q, clr_q, wr_addr;
	logic             clr_q_busy;
	logic             upd, wr_en;
	logic             hit, free;
	logic [WIW-1:0]   hit_idx, free_idx;
	logic [REF_W-1:0] hit_ref;

	// Clearing pass after reset, one row a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clr_q_busy <= 1'b1;
		end else if (clr_q_busy) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == BW'(BUCKETS - 1)) begin
				clr_q_busy <= 1'b0;
			end
		end
	end

	// Probe: first matching valid slot and first free slot.
	always_comb begin
		hit = 1'b0;
		free = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		hit_ref = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (row_q[w*SLOT_W + SLOT_W-1]) begin
				if (!hit && row_q[w*SLOT_W + REF_W +: KEY_W] == req.key) begin
					hit = 1'b1;
					hit_idx = w[WIW-1:0];
					hit_ref = row_q[w*SLOT_W +: REF_W];
				end
			end else if (!free) begin
				free = 1'b1;
				free_idx = w[WIW-1:0];
			end
		end
	end

	// Result and the changed row.
	always_comb begin
		new_row = row_q;
		upd = 1'b0;
		result.found_ref = '0;
		result.status = ST_NOT_FOUND;
		case (req.command)
			CMD_LOOKUP: begin
				if (hit) begin
					result.status = ST_DONE;
					result.found_ref = hit_ref;
				end
			end
			CMD_INSERT: begin
				if (hit) begin
					result.status = ST_DUPLICATE;
				end else if (!free) begin
					result.status = ST_FULL;
				end else begin
					result.status = ST_DONE;
					upd = 1'b1;
					new_row[free_idx*SLOT_W +: SLOT_W] = {1'b1, req.key, req.book_ref};
				end
			end
			CMD_REMOVE: begin
				if (hit) begin
					result.status = ST_DONE;
					upd = 1'b1;
					new_row[hit_idx*SLOT_W + SLOT_W-1] = 1'b0;
				end
			end
			default: begin
				result.status = ST_NOT_FOUND;
			end
		endcase
	end

	assign wr_en = clr_q_busy || (commit && upd);
	assign wr_addr = clr_q_busy ? clr_q : addr_q;
	assign wr_data = clr_q_busy ? '0 : new_row;

	// Memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			row_q <= mem[rd_addr];
			addr_q <= rd_addr;
		end
	end

	assign wr_active = commit && upd;
	assign clr_busy = clr_q_busy;

endmodule

// File: sv/hashed_key_table.sv
// Hashed key table: lookup, insert and remove of 44-bit keys with 16-bit
// references, BUCKETS buckets of WAYS slots each. A transaction, once
// accepted, runs through the two 64-bit multiplies of the mix on the shared
// 32x32 multiplier, the modulo by the bucket count, the hand-over of the
// bucket to the table, the read of the bucket's row and the evaluation and
// write-back of that row, which waits while the last result is not taken;
// the next request is accepted after the write-back. One request is
// worked on at a time; a new one is accepted while the last result waits.
// After reset a clearing pass over all BUCKETS rows runs before the first
// request is accepted. Depends on hkt_pkg, hkt_bucket and hkt_table.
`timescale 1ns / 1ps

module hashed_key_table #(
	parameter int BUCKETS = hkt_pkg::DEF_BUCKETS,
	parameter int WAYS = hkt_pkg::DEF_WAYS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // command[1:0], key[45:2], book_ref[61:46]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // status[1:0], found_ref[17:2]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hkt_pkg::*;

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_HASH = 4'b0010,
		S_READ = 4'b0100,
		S_EVAL = 4'b1000
	} state_t;

	state_t state_q;
	req_t req_q;
	result_t res, out_q;
	logic out_valid_q;
	logic [BCOUNT_W-1:0] bcount_q;
	logic [16:0] cnt17, cnt_eff;
	logic [NEFF_W-1:0] n_eff;
	logic accept, hash_done, commit, clr_busy, wr_active, cfg_wr;
	logic [BW-1:0] bucket;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Bucket count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q <= BUCKET_COUNT_RESET;
		end else if (cfg_wr && paddr[2] == 1'(REG_BUCKET_COUNT)) begin
			bcount_q <= pwdata[BCOUNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == 1'(REG_BUCKET_COUNT)) ?
		{{(32-BCOUNT_W){1'b0}}, bcount_q} : 32'b0;

	// Count in use: zero acts as one, and it never exceeds BUCKETS.
	always_comb begin
		cnt17 = {8'b0, bcount_q};
		if (cnt17 == 17'd0) begin
			cnt_eff = 17'd1;
		end else if (cnt17 > 17'(BUCKETS)) begin
			cnt_eff = 17'(BUCKETS);
		end else begin
			cnt_eff = cnt17;
		end
	end
	assign n_eff = cnt_eff[NEFF_W-1:0];

	assign s_tready = (state_q == S_IDLE) && !clr_busy;
	assign accept = s_tvalid && s_tready;
	assign commit = (state_q == S_EVAL) && (!out_valid_q || m_tready);

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_HASH;
				S_HASH: if (hash_done) state_q <= S_READ;
				S_READ: state_q <= S_EVAL;
				S_EVAL: if (commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= '{command: s_tdata[1:0], key: s_tdata[45:2], book_ref: s_tdata[61:46]};
		end
	end

	hkt_bucket #(.BUCKETS(BUCKETS), .BW(BW)) u_bucket (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.key(s_tdata[45:2]),
		.n_eff(n_eff),
		.done(hash_done),
		.bucket(bucket)
	);

	hkt_table #(.BUCKETS(BUCKETS), .WAYS(WAYS), .BW(BW)) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(state_q == S_READ),
		.rd_addr(bucket),
		.req(req_q),
		.commit(commit),
		.result(res),
		.wr_active(wr_active),
		.clr_busy(clr_busy)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'b0, out_q.found_ref, out_q.status};

	// Checks.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_tready) else $error("request accepted during clearing");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready) else $error("second request accepted while busy");
	a_write_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		wr_active |-> (state_q == S_EVAL)) else $error("table write outside evaluation");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!m_tvalid || m_tready)) else $error("result overwritten");

endmodule
